// ===== src/assert_macros.svh =====
// assertion macros used by the checker file bts_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bts_pkg.sv =====
// shared types and constants of the bounded suitor store
`timescale 1ns / 1ps

package bts_pkg;

    localparam int DEF_NUM_VERTICES = 1024;
    localparam int DEF_MAX_SUITORS  = 8;

    localparam int CMD_W    = 2;
    localparam int VERT_W   = 10;
    localparam int ID_W     = 10;
    localparam int WEIGHT_W = 32;
    localparam int CAP_W    = 4;
    localparam int COUNT_W  = 4;

    localparam logic [CAP_W-1:0] CAP_RST = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_BUMP   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_SCAN,
        ST_WRITE
    } t_bstate;

    typedef struct packed {
        t_cmd                cmd;
        logic [VERT_W-1:0]   vertex;
        logic [ID_W-1:0]     cand_id;
        logic [WEIGHT_W-1:0] weight;
        logic                in_range;
    } t_item;

    typedef struct packed {
        logic               inserted;
        logic               removed;
        logic [ID_W-1:0]    evicted_id;
        logic               found;
        logic               full_error;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== src/bts_front.sv =====
// front part: takes commands, checks the vertex range, two-entry queue to the back part
`timescale 1ns / 1ps

module bts_front #(
    parameter int NUM_VERTICES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bts_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bts_pkg::VERT_W-1:0]    i_vertex,
    input  logic [bts_pkg::ID_W-1:0]      i_cand_id,
    input  logic [bts_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                          o_q_valid,
    output bts_pkg::t_item                o_q_item,
    input  logic                          i_q_pop
);
    import bts_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      item_c;
    logic       push;

    always_comb begin
        item_c.cmd      = t_cmd'(i_cmd);
        item_c.vertex   = i_vertex;
        item_c.cand_id  = i_cand_id;
        item_c.weight   = i_weight;
        item_c.in_range = ({22'd0, i_vertex} < 32'(NUM_VERTICES));
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item_c;
        end
    end

endmodule

// ===== src/bts_back.sv =====
// back part: per-vertex metadata and slot memories, slot scan and write-back
`timescale 1ns / 1ps

module bts_back #(
    parameter int NUM_VERTICES = 1024,
    parameter int MAX_SUITORS  = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bts_pkg::CAP_W-1:0]   i_cap,
    input  logic                        i_q_valid,
    input  bts_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bts_pkg::t_result            o_res
);
    import bts_pkg::*;

    localparam int VAW   = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int SW    = (MAX_SUITORS > 1) ? $clog2(MAX_SUITORS) : 1;
    localparam int CW    = $clog2(MAX_SUITORS + 1);
    localparam int NSLOT = NUM_VERTICES * MAX_SUITORS;
    localparam int AW    = $clog2(NSLOT);
    localparam int MW    = CW + MAX_SUITORS;
    localparam int DW    = ID_W + WEIGHT_W;

    // metadata per vertex: {count, valid mask}
    logic [MW-1:0] meta_mem [NUM_VERTICES];
    logic [DW-1:0] slot_mem [NSLOT];

    t_bstate          r_state, n_state;
    t_item            r_item;
    logic [VAW-1:0]   r_vidx;
    logic [AW-1:0]    r_base;
    logic [VAW-1:0]   r_clr;
    logic [CW-1:0]    r_scan;
    logic [MW-1:0]    r_meta_q;
    logic [DW-1:0]    r_slot_q;
    logic             r_hit;
    logic [SW-1:0]    r_hit_slot;
    logic             r_free;
    logic [SW-1:0]    r_free_slot;
    logic             r_minv;
    logic [SW-1:0]    r_min_slot;
    logic [WEIGHT_W-1:0] r_min_w;
    logic [ID_W-1:0]  r_min_id;
    logic             r_out_valid;
    t_result          r_res;

    logic [CW-1:0]    cap_eff;
    logic [MAX_SUITORS-1:0] mask;
    logic [CW-1:0]    cnt;
    logic [SW-1:0]    sidx;
    logic             s_valid;
    logic [ID_W-1:0]  s_id;
    logic [WEIGHT_W-1:0] s_w;
    logic [CW-1:0]    rd_slot;
    logic [AW-1:0]    rd_addr;
    logic             pop;
    logic             scan_last;

    logic             st_en;
    logic [SW-1:0]    st_slot;
    logic [MAX_SUITORS-1:0] n_mask;
    logic [CW-1:0]    n_cnt;
    t_result          res_c;
    logic             meta_we;
    logic [VAW-1:0]   meta_wa;
    logic [MW-1:0]    meta_wd;

    // capacity clamped to 1..MAX_SUITORS
    always_comb begin
        if (i_cap == '0) begin
            cap_eff = CW'(1);
        end else if (32'(i_cap) > MAX_SUITORS) begin
            cap_eff = CW'(MAX_SUITORS);
        end else begin
            cap_eff = CW'(i_cap);
        end
    end

    assign mask      = r_meta_q[MAX_SUITORS-1:0];
    assign cnt       = r_meta_q[MW-1:MAX_SUITORS];
    assign sidx      = r_scan[SW-1:0];
    assign s_valid   = mask[sidx];
    assign s_id      = r_slot_q[DW-1:WEIGHT_W];
    assign s_w       = r_slot_q[WEIGHT_W-1:0];
    assign scan_last = (32'(r_scan) == MAX_SUITORS - 1);
    assign pop       = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
    assign o_q_pop   = pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr) == NUM_VERTICES - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    n_state = ST_META;
                end
            end
            ST_META: begin
                n_state = r_item.in_range ? ST_SCAN : ST_WRITE;
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read address: slot 0 while the metadata is read, then one slot ahead of the scan
    always_comb begin
        rd_slot = (r_state == ST_META) ? '0 : r_scan + CW'(1);
        rd_addr = r_base + AW'(rd_slot);
    end

    // command decision on the scan results
    always_comb begin
        st_en   = 1'b0;
        st_slot = r_free_slot;
        n_mask  = mask;
        n_cnt   = cnt;
        res_c   = '0;
        if (r_item.in_range) begin
            res_c.found = r_hit;
            case (r_item.cmd)
                CMD_BUMP: begin
                    if (cnt >= cap_eff) begin
                        if (r_minv && (r_item.weight > r_min_w)) begin
                            st_en            = 1'b1;
                            st_slot          = r_min_slot;
                            res_c.removed    = 1'b1;
                            res_c.evicted_id = r_min_id;
                            res_c.inserted   = 1'b1;
                        end
                    end else if (r_free) begin
                        st_en          = 1'b1;
                        n_cnt          = cnt + CW'(1);
                        res_c.inserted = 1'b1;
                    end
                end
                CMD_ADD: begin
                    if (!r_hit) begin
                        if (cnt >= cap_eff) begin
                            res_c.full_error = 1'b1;
                        end else if (r_free) begin
                            st_en          = 1'b1;
                            n_cnt          = cnt + CW'(1);
                            res_c.inserted = 1'b1;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (r_hit) begin
                        n_mask[r_hit_slot] = 1'b0;
                        if (cnt != '0) begin
                            n_cnt = cnt - CW'(1);
                        end
                        res_c.removed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (st_en) begin
                n_mask[st_slot] = 1'b1;
            end
            res_c.count = COUNT_W'(n_cnt);
        end
    end

    // metadata port: clearing pass or write-back
    always_comb begin
        meta_we = 1'b0;
        meta_wa = r_vidx;
        meta_wd = {n_cnt, n_mask};
        if (r_state == ST_CLEAR) begin
            meta_we = 1'b1;
            meta_wa = r_clr;
            meta_wd = '0;
        end else if ((r_state == ST_WRITE) && r_item.in_range) begin
            meta_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        r_meta_q <= meta_mem[r_vidx];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WRITE) && st_en) begin
            slot_mem[r_base + AW'(st_slot)] <= {r_item.cand_id, r_item.weight};
        end
        r_slot_q <= slot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + VAW'(1);
            end
            if (r_state == ST_WRITE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and scan trackers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_q_item;
            r_vidx <= VAW'({22'd0, i_q_item.vertex});
            r_base <= AW'(32'(i_q_item.vertex) * MAX_SUITORS);
        end
        if (r_state == ST_META) begin
            r_scan <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_minv <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_scan <= r_scan + CW'(1);
            if (s_valid && (s_id == r_item.cand_id) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= sidx;
            end
            if (!s_valid && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= sidx;
            end
            if (s_valid && (!r_minv || (s_w < r_min_w))) begin
                r_minv     <= 1'b1;
                r_min_slot <= sidx;
                r_min_w    <= s_w;
                r_min_id   <= s_id;
            end
        end
        if (r_state == ST_WRITE) begin
            r_res <= res_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ===== src/bounded_top_b_suitor_store_top.sv =====
// top level of the bounded top-b suitor store
`timescale 1ns / 1ps

// Keeps up to MAX_SUITORS suitors (id, weight) for each of NUM_VERTICES vertices.
// Input channel i_in_valid / o_in_ready carries one command per transaction:
// bump, add if absent, remove by id or query. Output channel o_out_valid /
// i_out_ready returns one result per command, in command order.
// i_cfg_wr_en with i_cfg_wr_data sets the capacity; write it only while idle.
// The back part takes one command at a time: it takes the command from the queue,
// reads the metadata and, for a vertex in range, scans one slot per cycle through
// the single read port of the slot memory and writes back; it then waits until the
// result register is taken. A two-entry queue lets commands arrive while one is at work.
// After reset a clearing pass over every vertex zeroes the per-vertex counts and
// valid masks; commands are queued but not started until it ends.
// When the receiver stalls, the result is held and the next command waits in
// the queue; input stalls once the queue is full.
module bounded_top_b_suitor_store_top #(
    parameter int NUM_VERTICES = bts_pkg::DEF_NUM_VERTICES,
    parameter int MAX_SUITORS  = bts_pkg::DEF_MAX_SUITORS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bts_pkg::CAP_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bts_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bts_pkg::VERT_W-1:0]    i_vertex,
    input  logic [bts_pkg::ID_W-1:0]      i_cand_id,
    input  logic [bts_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_inserted,
    output logic                          o_removed,
    output logic [bts_pkg::ID_W-1:0]      o_evicted_id,
    output logic                          o_found,
    output logic                          o_full_error,
    output logic [bts_pkg::COUNT_W-1:0]   o_count
);
    import bts_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RST;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    bts_front #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_vertex    (i_vertex),
        .i_cand_id   (i_cand_id),
        .i_weight    (i_weight),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    bts_back #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_SUITORS  (MAX_SUITORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_inserted   = res.inserted;
    assign o_removed    = res.removed;
    assign o_evicted_id = res.evicted_id;
    assign o_found      = res.found;
    assign o_full_error = res.full_error;
    assign o_count      = res.count;

endmodule

// ===== src/bts_checker.sv =====
// port-level checks of the suitor store, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_inserted,
    input logic                          o_removed,
    input logic [bts_pkg::ID_W-1:0]      o_evicted_id,
    input logic                          o_full_error
);
    import bts_pkg::*;

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")

    // no result straight out of reset
    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a full set never also stores the new suitor
    `ASSERT_CLK(a_err_excl, i_clk, i_rst_n, o_out_valid |-> !(o_inserted && o_full_error), "insert with full error")

    // an evicted id only comes with a replacement
    `ASSERT_CLK(a_evict, i_clk, i_rst_n, o_out_valid && (o_evicted_id != '0) |-> o_removed && o_inserted, "evicted id without replacement")

endmodule

bind bounded_top_b_suitor_store_top bts_checker u_bts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_inserted   (o_inserted),
    .o_removed    (o_removed),
    .o_evicted_id (o_evicted_id),
    .o_full_error (o_full_error)
);

// ===== dv/tb_bounded_top_b_suitor_store_top.sv =====
// self-checking testbench of the bounded top-b suitor store
`timescale 1ns / 1ps

module tb_bounded_top_b_suitor_store_top;
    import bts_pkg::*;

    localparam int NV = DEF_NUM_VERTICES;
    localparam int NS = DEF_MAX_SUITORS;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 4 * (NS + 4);

    typedef struct packed {
        t_cmd                cmd;
        logic [VERT_W-1:0]   vertex;
        logic [ID_W-1:0]     cand_id;
        logic [WEIGHT_W-1:0] weight;
    } t_cmd_item;

    // directed row: command, whether an exact result is typed in, and that result
    typedef struct packed {
        t_cmd_item item;
        logic      fixed;
        t_result   res;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]    i_cfg_wr_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_cmd = '0;
    logic [VERT_W-1:0]   i_vertex = '0;
    logic [ID_W-1:0]     i_cand_id = '0;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_inserted;
    logic                o_removed;
    logic [ID_W-1:0]     o_evicted_id;
    logic                o_found;
    logic                o_full_error;
    logic [COUNT_W-1:0]  o_count;

    bounded_top_b_suitor_store_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_vertex(i_vertex), .i_cand_id(i_cand_id), .i_weight(i_weight),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_inserted(o_inserted), .o_removed(o_removed), .o_evicted_id(o_evicted_id),
        .o_found(o_found), .o_full_error(o_full_error), .o_count(o_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the suitor sets
    logic                sh_valid [NV*NS];
    logic [ID_W-1:0]     sh_id    [NV*NS];
    logic [WEIGHT_W-1:0] sh_weight[NV*NS];
    logic [COUNT_W-1:0]  sh_count [NV];
    logic [CAP_W-1:0]    sh_cap_reg;

    t_result expected_results[$];
    t_row    directed[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    function automatic t_result suitor_update(t_cmd_item it);
        t_result r;
        int base, hit, freeslot, mn, capn, c;
        logic full;
        r = '0;
        if (int'(it.vertex) >= NV) return r;
        base = int'(it.vertex) * NS;
        capn = (sh_cap_reg < 1) ? 1 : ((sh_cap_reg > NS) ? NS : int'(sh_cap_reg));
        c = sh_count[it.vertex];
        hit = -1; freeslot = -1; mn = -1;
        for (int s = 0; s < NS; s++) begin
            if (sh_valid[base+s] && sh_id[base+s] == it.cand_id && hit < 0) hit = s;
            if (!sh_valid[base+s] && freeslot < 0) freeslot = s;
            if (sh_valid[base+s] && (mn < 0 || sh_weight[base+s] < sh_weight[base+mn])) mn = s;
        end
        full = (c >= capn);
        r.found = (hit >= 0);
        case (it.cmd)
            CMD_BUMP: begin
                if (full) begin
                    if (mn >= 0 && it.weight > sh_weight[base+mn]) begin
                        r.removed = 1'b1;
                        r.evicted_id = sh_id[base+mn];
                        sh_id[base+mn] = it.cand_id;
                        sh_weight[base+mn] = it.weight;
                        r.inserted = 1'b1;
                    end
                end else if (freeslot >= 0) begin
                    sh_valid[base+freeslot] = 1'b1;
                    sh_id[base+freeslot] = it.cand_id;
                    sh_weight[base+freeslot] = it.weight;
                    c++;
                    r.inserted = 1'b1;
                end
            end
            CMD_ADD: begin
                if (hit < 0) begin
                    if (full) r.full_error = 1'b1;
                    else if (freeslot >= 0) begin
                        sh_valid[base+freeslot] = 1'b1;
                        sh_id[base+freeslot] = it.cand_id;
                        sh_weight[base+freeslot] = it.weight;
                        c++;
                        r.inserted = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    sh_valid[base+hit] = 1'b0;
                    if (c > 0) c--;
                    r.removed = 1'b1;
                end
            end
            default: ;
        endcase
        sh_count[it.vertex] = c[COUNT_W-1:0];
        r.count = c[COUNT_W-1:0];
        return r;
    endfunction

    // valid is only dropped while idling, so each transaction gets one assignment per step
    task automatic send_cmd(t_cmd_item it, logic fixed, t_result fixed_res);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= it.cmd;
        i_vertex    <= it.vertex;
        i_cand_id   <= it.cand_id;
        i_weight    <= it.weight;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = suitor_update(it);
        expected_results = {expected_results, (fixed ? fixed_res : pred)};
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (NS + 8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sh_cap_reg = value;
    endtask

    function automatic t_cmd_item mk_item(t_cmd c, int v, int id, logic [WEIGHT_W-1:0] w);
        t_cmd_item it;
        it.cmd     = c;
        it.vertex  = VERT_W'(v);
        it.cand_id = ID_W'(id);
        it.weight  = w;
        return it;
    endfunction

    function automatic t_cmd_item random_cmd(int nverts, int nids);
        t_cmd_item it;
        it.cmd = t_cmd'(CMD_W'($urandom_range(3)));
        it.vertex = VERT_W'($urandom_range(nverts - 1));
        it.cand_id = ID_W'($urandom_range(nids - 1));
        case ($urandom_range(3))
            0: it.weight = $urandom_range(7);
            1: it.weight = $urandom();
            2: it.weight = {$urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(15);
            default: it.weight = $urandom_range(40);
        endcase
        // rare wide vertex and id to toggle every bit
        if ($urandom_range(15) == 0) it.vertex = VERT_W'($urandom());
        if ($urandom_range(15) == 0) it.cand_id = ID_W'($urandom());
        return it;
    endfunction

    // receiver with random stall and field-by-field compare
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_inserted !== e.inserted) begin
                        $error("inserted exp %0d got %0d", e.inserted, o_inserted); fail_count++;
                    end
                    if (o_removed !== e.removed) begin
                        $error("removed exp %0d got %0d", e.removed, o_removed); fail_count++;
                    end
                    if (o_evicted_id !== e.evicted_id) begin
                        $error("evicted_id exp %0d got %0d", e.evicted_id, o_evicted_id);
                        fail_count++;
                    end
                    if (o_found !== e.found) begin
                        $error("found exp %0d got %0d", e.found, o_found); fail_count++;
                    end
                    if (o_full_error !== e.full_error) begin
                        $error("full_error exp %0d got %0d", e.full_error, o_full_error);
                        fail_count++;
                    end
                    if (o_count !== e.count) begin
                        $error("count exp %0d got %0d", e.count, o_count); fail_count++;
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_row mk(t_cmd c, int v, int id, logic [31:0] w, int fx,
                                int ins, int rem, int ev, int fnd, int fe, int cnt);
        t_row r;
        r.item = mk_item(c, v, id, w);
        r.fixed = (fx != 0);
        r.res = '{inserted: (ins != 0), removed: (rem != 0), evicted_id: ID_W'(ev),
                  found: (fnd != 0), full_error: (fe != 0), count: COUNT_W'(cnt)};
        return r;
    endfunction

    function automatic void add_row(t_row r);
        directed = {directed, r};
    endfunction

    initial begin
        t_result none;
        int ph;
        none = '0;
        for (int i = 0; i < NV*NS; i++) begin
            sh_valid[i] = 1'b0; sh_id[i] = '0; sh_weight[i] = '0;
        end
        for (int i = 0; i < NV; i++) sh_count[i] = '0;
        sh_cap_reg = CAP_RST;

        // after reset, extremes, full set and error codes
        add_row(mk(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_REMOVE, 1023, 1023, 0, 1, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_BUMP, 1023, 1023, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 1));
        add_row(mk(CMD_QUERY, 1023, 1023, 0, 1, 0, 0, 0, 1, 0, 1));
        add_row(mk(CMD_ADD, 1023, 1023, 5, 1, 0, 0, 0, 1, 0, 1));
        add_row(mk(CMD_REMOVE, 1023, 1023, 0, 1, 0, 1, 0, 1, 0, 0));
        for (int i = 0; i < 8; i++)
            add_row(mk(CMD_ADD, 5, 100 + i, (i == 3 || i == 6) ? 2 : 10 + i,
                       0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_ADD, 5, 200, 50, 1, 0, 0, 0, 0, 1, 8));
        add_row(mk(CMD_BUMP, 5, 201, 2, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_BUMP, 5, 202, 3, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_BUMP, 5, 202, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_REMOVE, 5, 202, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_BUMP, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(CMD_QUERY, 5, 202, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_cmd(directed[k].item, directed[k].fixed, directed[k].res);

        // lowered capacity leaves sets over-full
        write_capacity(4'd2);
        send_cmd(mk_item(CMD_BUMP, 5, 7, 32'h7FFF_FFFF), 1'b0, none);
        send_cmd(mk_item(CMD_ADD, 5, 8, 1), 1'b0, none);
        write_capacity(4'd0);
        send_cmd(mk_item(CMD_ADD, 9, 1, 1), 1'b0, none);
        send_cmd(mk_item(CMD_ADD, 9, 2, 1), 1'b0, none);
        write_capacity(4'd15);
        send_cmd(mk_item(CMD_ADD, 9, 3, 1), 1'b0, none);

        for (int n = 0; n < 1250; n++) begin
            ph = n / 125;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (n % 250 == 249) begin
                case ((n / 250) % 5)
                    0: write_capacity(4'd1);
                    1: write_capacity(4'd8);
                    2: write_capacity(4'd3);
                    3: write_capacity(CAP_W'($urandom_range(15)));
                    default: write_capacity(4'd5);
                endcase
            end
            // few vertices and ids so sets fill and ids collide
            send_cmd(random_cmd(4, 12), 1'b0, none);
        end

        i_in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
